// File: design/lru_page_victim_select_macros.svh
// assertion macros for the lru page victim selector
// clocked on clk_i, held off while rst_ni is low
`ifndef LRU_PAGE_VICTIM_SELECT_MACROS_SVH
`define LRU_PAGE_VICTIM_SELECT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define LPVS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lpvs check failed");

`define LPVS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lpvs check failed");

`else

`define LPVS_ASSERT_IMPL(label, ante, cons)

`define LPVS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: design/lpvs_pkg.sv
`timescale 1ns / 1ps

package lpvs_pkg;

  localparam int PROCESSES      = 32;
  localparam int PAGES_PER_PROC = 32;
  localparam int PAGE_SIZE      = 128;  // power of two
  localparam int STAMP_BITS     = 32;

  localparam int PAGE_SHIFT = $clog2(PAGE_SIZE);
  localparam int TABLE_DEPTH = PROCESSES * PAGES_PER_PROC;
  localparam int ADDR_W     = $clog2(TABLE_DEPTH);
  localparam int PAGE_W     = $clog2(PAGES_PER_PROC);
  localparam int CNT_W      = $clog2(PAGES_PER_PROC + 1);

  // item kinds
  localparam logic [1:0] FUNC_ACCESS = 2'd0;
  localparam logic [1:0] FUNC_EVICT  = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [4:0]  proc;
    logic        active;
    logic [11:0] pc;
    logic        resident;
    logic        pagein_started;
    logic [4:0]  evicted_page;
    logic        pageout_started;
  } in_beat_t;

  typedef struct packed {
    logic       evict_request;
    logic [4:0] victim_page;
    logic       no_victim;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic clr_we;
    logic capture;
    logic exec;
    logic scan_init;
    logic scan_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_search;
    logic scan_last;
    logic out_free;
  } status_t;

endpackage

// File: design/lpvs_ram.sv
`timescale 1ns / 1ps

module lpvs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/lpvs_ctrl.sv
`timescale 1ns / 1ps

module lpvs_ctrl import lpvs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    in_stall_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (status_i.is_search) begin
          cmd_o.scan_init = 1'b1;
          state_d         = ST_SCAN;
        end else begin
          state_d = ST_RESULT;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/lpvs_dp.sv
`timescale 1ns / 1ps

module lpvs_dp import lpvs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_beat_t  in_data_i,
  input  cmd_t      cmd_i,
  output status_t   status_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  in_beat_t              item_q;
  logic [STAMP_BITS-1:0] tick_q;
  logic [ADDR_W-1:0]     clr_cnt_q;
  logic [CNT_W-1:0]      scan_cnt_q;
  logic [STAMP_BITS-1:0] best_q;
  logic [PAGE_W-1:0]     victim_q;
  logic                  found_q;
  logic                  out_valid_q;
  out_beat_t             out_q;

  logic [11:0]           page;
  logic                  proc_ok;
  logic                  evict_wr;
  logic                  access_ok;
  logic                  stamp_wr;
  logic                  search;
  logic [ADDR_W-1:0]     base;
  logic [ADDR_W-1:0]     acc_addr;
  logic [ADDR_W-1:0]     evp_addr;
  logic                  scan_rd;
  logic                  scan_cmp;
  logic [PAGE_W-1:0]     cmp_idx;
  logic [STAMP_BITS-1:0] rd_data;

  logic                  ram_we;
  logic                  ram_re;
  logic [ADDR_W-1:0]     ram_addr;
  logic [STAMP_BITS-1:0] ram_wdata;

  // item decode
  always_comb begin
    page      = item_q.pc >> PAGE_SHIFT;
    proc_ok   = 32'(item_q.proc) < 32'(PROCESSES);
    evict_wr  = (item_q.func == FUNC_EVICT) && proc_ok && item_q.pageout_started &&
                (32'(item_q.evicted_page) < 32'(PAGES_PER_PROC));
    access_ok = (item_q.func == FUNC_ACCESS) && proc_ok && item_q.active &&
                (32'(page) < 32'(PAGES_PER_PROC));
    stamp_wr  = access_ok && item_q.resident;
    search    = access_ok && !item_q.resident && !item_q.pagein_started;
    base      = ADDR_W'(ADDR_W'(item_q.proc) * ADDR_W'(PAGES_PER_PROC));
    acc_addr  = base + ADDR_W'(page);
    evp_addr  = base + ADDR_W'(item_q.evicted_page);
    scan_rd   = cmd_i.scan_step && (32'(scan_cnt_q) < 32'(PAGES_PER_PROC));
    scan_cmp  = cmd_i.scan_step && (scan_cnt_q != '0);
    cmp_idx   = PAGE_W'(scan_cnt_q - CNT_W'(1));
  end

  // single table port: clearing pass, stamp update, search reads
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = clr_cnt_q;
    ram_wdata = '0;
    if (cmd_i.clr_we) begin
      ram_we = 1'b1;
    end else if (cmd_i.exec && (evict_wr || stamp_wr)) begin
      ram_we    = 1'b1;
      ram_addr  = stamp_wr ? acc_addr : evp_addr;
      ram_wdata = stamp_wr ? tick_q : '0;
    end else if (scan_rd) begin
      ram_re   = 1'b1;
      ram_addr = base + ADDR_W'(scan_cnt_q[PAGE_W-1:0]);
    end
  end

  lpvs_ram #(
    .WIDTH (STAMP_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q      <= STAMP_BITS'(1);
      clr_cnt_q   <= '0;
      scan_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_we) begin
        clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
      end
      if (cmd_i.exec && (item_q.func == FUNC_TICK) && (tick_q != '1)) begin
        tick_q <= tick_q + STAMP_BITS'(1);
      end
      if (cmd_i.scan_init) begin
        scan_cnt_q <= '0;
      end else if (cmd_i.scan_step && !status_o.scan_last) begin
        scan_cnt_q <= scan_cnt_q + CNT_W'(1);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_data_i;
    end
    if (cmd_i.scan_init) begin
      best_q   <= tick_q;
      victim_q <= '0;
      found_q  <= 1'b0;
    end else if (scan_cmp && (rd_data != '0) && (rd_data < best_q)) begin
      best_q   <= rd_data;
      victim_q <= cmp_idx;
      found_q  <= 1'b1;
    end
    if (cmd_i.load_out) begin
      out_q.evict_request <= search && found_q;
      out_q.victim_page   <= (search && found_q) ? 5'(victim_q) : 5'd0;
      out_q.no_victim     <= search && !found_q;
    end
  end

  always_comb begin
    status_o.clr_last  = (clr_cnt_q == ADDR_W'(TABLE_DEPTH - 1));
    status_o.is_search = search;
    status_o.scan_last = (32'(scan_cnt_q) == 32'(PAGES_PER_PROC));
    status_o.out_free  = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: design/lru_page_victim_select.sv
`timescale 1ns / 1ps
// lru page victim selector
// input channel: one beat per item (access check, eviction outcome or tick),
// handshake in_valid_i / in_stall_o; output channel: exactly one result beat
// per item on out_valid_o / out_stall_i
// sequencing: tick, eviction outcome and non-searching access checks pass
// from acceptance through the execute state to the result state; an access
// check that searches for a victim also passes a scan state that reads the
// process's stamps one per cycle through the single port of the stamp table
// throughput: one item in flight; the next beat is taken once the previous
// item's result sits in the output register, even if that result is stalled
// reset: the stamp table is swept to zero, one entry a cycle, over all
// PROCESSES * PAGES_PER_PROC entries (1024); in_stall_o is high meanwhile and
// the tick restarts at one
// a stalled output holds its beat; a finished item waits for the output
// register to empty before it retires, keeping input stalled
`include "lru_page_victim_select_macros.svh"

module lru_page_victim_select import lpvs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  cmd_t    cmd;
  status_t status;

  // sequencer: clear sweep, item execute, stamp scan, result retire
  lpvs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // datapath: stamp table, tick, min search, output register
  lpvs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // a victim and the no-victim flag never come together
  `LPVS_ASSERT_IMPL(a_victim_excl, out_valid_o && out_data_o.evict_request,
                    !out_data_o.no_victim)

  // accepting a beat always makes the block busy the next cycle
  `LPVS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  // a result only lands in the output register when it is free
  `LPVS_ASSERT_IMPL(a_load_free, cmd.load_out, !out_valid_o || !out_stall_i)

endmodule
